### hdl/sorted_seq_number_insert_core_macros.svh
// Assertion helpers, clocked on clk_i and quiet during reset.
`ifndef SORTED_SEQ_NUMBER_INSERT_CORE_MACROS_SVH
`define SORTED_SEQ_NUMBER_INSERT_CORE_MACROS_SVH

// Condition that holds at every clock edge.
`define SSI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed: invariant");

// Consequent that holds in the cycle after the antecedent.
`define SSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/ssi_pkg.sv
package ssi_pkg;

  localparam int unsigned SEQ_W = 16;
  localparam int unsigned POS_W = 9;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // b follows a when (b - a) mod 2^16 is nonzero and below half range
  function automatic logic seq_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

### hdl/sorted_seq_number_insert_core.sv
// Channel  Direction  Handshake                  Payload
// -------  ---------  -------------------------  -------------------------------
// in       input      in_valid_i / in_ready_o    new_seq_i
// out      output     out_valid_o / out_ready_i  status_o, position_o, count_o
//
// One transfer in gives one transfer out. Items are handled one at a time.
// An empty or full list needs no search, an append only compares the last
// entry, a duplicate takes P binary-search probes (at most log2(count) + 1)
// and a search insert takes P probes and then moves S = count - position
// entries up, all through the single entry RAM (one read and one write port,
// registered read data).
// Reset clears the entry count and all control; the RAM is not cleared.
// A result that is not taken holds the output register and stalls the
// next item only once that item is finished.
`include "sorted_seq_number_insert_core_macros.svh"

module sorted_seq_number_insert_core
  import ssi_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SEQ_W-1:0] new_seq_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [POS_W-1:0] position_o,
  output logic [POS_W-1:0] count_o
);

  // AW indexes the RAM, CW also holds LIST_DEPTH itself
  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a transfer
  localparam logic [2:0] S_LAST  = 3'd1;  // compare against last entry
  localparam logic [2:0] S_SRCH  = 3'd2;  // one binary-search probe per cycle
  localparam logic [2:0] S_SHIFT = 3'd3;  // move one entry up per cycle
  localparam logic [2:0] S_PUT   = 3'd4;  // write the new number into the gap
  localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

  logic [2:0]       state_q, state_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    lo_q, lo_d;       // search window [lo, hx)
  logic [CW-1:0]    hx_q, hx_d;
  logic [AW-1:0]    mid_q, mid_d;
  logic [AW-1:0]    ptr_q, ptr_d;     // shift destination
  logic [AW-1:0]    idx_q, idx_d;     // insert position

  status_e          res_stat_q, res_stat_d;
  logic [CW-1:0]    res_pos_q, res_pos_d;
  logic [CW-1:0]    res_cnt_q, res_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_stat_q, out_stat_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic [POS_W-1:0] out_cnt_q, out_cnt_d;

  // Entry RAM. Shift reads entry p-1 while it writes entry p+1, so a shift read
  // never hits the address written in the same cycle; no forwarding needed.
  logic [SEQ_W-1:0] mem_q [LIST_DEPTH];
  logic [SEQ_W-1:0] rd_data_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SEQ_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // search scratch
  logic [CW-1:0]    lo_n, hx_n;
  logic [CW:0]      mid_sum;
  logic [AW-1:0]    mid_n;
  logic [AW-1:0]    idx_n;
  logic             stop;
  logic [CW-1:0]    cnt_m1;
  logic [CW+POS_W-1:0] pos_ext, cnt_ext;

  assign cnt_m1  = cnt_q - CW'(1);
  assign pos_ext = {{POS_W{1'b0}}, res_pos_q};
  assign cnt_ext = {{POS_W{1'b0}}, res_cnt_q};

  always_comb begin
    state_d     = state_q;
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hx_d        = hx_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    res_stat_d  = res_stat_q;
    res_pos_d   = res_pos_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = seq_q;
    mem_raddr   = '0;
    lo_n        = lo_q;
    hx_n        = hx_q;
    mid_sum     = '0;
    mid_n       = '0;
    idx_n       = mid_q;
    stop        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          seq_d = new_seq_i;
          if (cnt_q == CW'(LIST_DEPTH)) begin
            // full: drop without searching, even a duplicate
            res_stat_d = STAT_FULL;
            res_pos_d  = CW'(LIST_DEPTH);
            res_cnt_d  = cnt_q;
            state_d    = S_DONE;
          end else if (cnt_q == '0) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = new_seq_i;
            cnt_d      = CW'(1);
            res_stat_d = STAT_INSERTED;
            res_pos_d  = '0;
            res_cnt_d  = CW'(1);
            state_d    = S_DONE;
          end else begin
            mem_raddr = cnt_m1[AW-1:0];
            state_d   = S_LAST;
          end
        end
      end

      S_LAST: begin
        if (seq_after(rd_data_q, seq_q)) begin
          // append
          mem_we     = 1'b1;
          mem_waddr  = cnt_q[AW-1:0];
          cnt_d      = cnt_q + CW'(1);
          res_stat_d = STAT_INSERTED;
          res_pos_d  = cnt_q;
          res_cnt_d  = cnt_q + CW'(1);
          state_d    = S_DONE;
        end else begin
          lo_n      = '0;
          hx_n      = cnt_q;
          mid_sum   = {1'b0, lo_n} + {1'b0, hx_n} - (CW+1)'(1);
          mid_n     = mid_sum[AW:1];
          lo_d      = lo_n;
          hx_d      = hx_n;
          mid_d     = mid_n;
          mem_raddr = mid_n;
          state_d   = S_SRCH;
        end
      end

      S_SRCH: begin
        if (rd_data_q == seq_q) begin
          res_stat_d = STAT_DUPLICATE;
          res_pos_d  = CW'(mid_q);
          res_cnt_d  = cnt_q;
          state_d    = S_DONE;
        end else begin
          if (seq_after(seq_q, rd_data_q)) begin
            hx_n = CW'(mid_q);
          end else if (seq_after(rd_data_q, seq_q)) begin
            lo_n = CW'(mid_q) + CW'(1);
          end else begin
            // exactly half range apart: take the probe's slot
            stop  = 1'b1;
            idx_n = mid_q;
          end
          if (!stop && (lo_n >= hx_n)) begin
            stop  = 1'b1;
            idx_n = lo_n[AW-1:0];
          end
          if (stop) begin
            idx_d = idx_n;
            if (CW'(idx_n) == cnt_q) begin
              state_d = S_PUT;
            end else begin
              mem_raddr = cnt_m1[AW-1:0];
              ptr_d     = cnt_q[AW-1:0];
              state_d   = S_SHIFT;
            end
          end else begin
            mid_sum   = {1'b0, lo_n} + {1'b0, hx_n} - (CW+1)'(1);
            mid_n     = mid_sum[AW:1];
            lo_d      = lo_n;
            hx_d      = hx_n;
            mid_d     = mid_n;
            mem_raddr = mid_n;
          end
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rd_data_q;
        ptr_d     = ptr_q - AW'(1);
        mem_raddr = ptr_q - AW'(2);
        if ((ptr_q - AW'(1)) == idx_q) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_q;
        mem_wdata  = seq_q;
        cnt_d      = cnt_q + CW'(1);
        res_stat_d = STAT_INSERTED;
        res_pos_d  = CW'(idx_q);
        res_cnt_d  = cnt_q + CW'(1);
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_pos_d   = pos_ext[POS_W-1:0];
          out_cnt_d   = cnt_ext[POS_W-1:0];
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    lo_q       <= lo_d;
    hx_q       <= hx_d;
    mid_q      <= mid_d;
    ptr_q      <= ptr_d;
    idx_q      <= idx_d;
    res_stat_q <= res_stat_d;
    res_pos_q  <= res_pos_d;
    res_cnt_q  <= res_cnt_d;
    out_stat_q <= out_stat_d;
    out_pos_q  <= out_pos_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign position_o  = out_pos_q;
  assign count_o     = out_cnt_q;

  // count stays within the list and grows by at most one per cycle
  `SSI_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(LIST_DEPTH))
  `SSI_ASSERT_ALWAYS(a_cnt_step, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
  // an accepted item always leaves idle
  `SSI_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, state_q != S_IDLE)
  // RAM is written in idle only by the transfer that fills an empty list
  `SSI_ASSERT_ALWAYS(a_idle_wr, !(mem_we && state_q == S_IDLE) || (in_valid_i && cnt_q == '0))

endmodule

### tb/sv/sorted_seq_number_insert_core_tb.sv
`timescale 1ns / 1ps

module sorted_seq_number_insert_core_tb;
  import ssi_pkg::*;

  localparam int unsigned LIST_DEPTH  = 256;
  localparam int unsigned DIR_ITEMS   = 18;
  localparam int unsigned RAND_ITEMS  = 1430;
  // Pause the source here until the result queue is empty.
  localparam int unsigned DRAIN_AT    = 700;
  // Covers the worst item's search and shift, plus source gaps and sink stalls.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam logic [SEQ_W-1:0] HALF_RANGE = SEQ_W'(1) << (SEQ_W - 1);

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
  } seq_result_t;

  // One stimulus row. When 'fixed' is set, 'result' is the hand-written answer;
  // otherwise the expectation comes from place_seq().
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             fixed;
    seq_result_t      result;
  } seq_row_t;

  // Sink behavior, changed every so often.
  typedef enum logic [1:0] {
    SINK_OPEN,    // always ready
    SINK_CHOPPY,  // ready about half the time
    SINK_CHOKED   // ready about one time in eight
  } sink_mode_e;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [SEQ_W-1:0] new_seq   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] count;

  // Shadow of the ordered list, updated at each accepted input transfer.
  logic [SEQ_W-1:0] held_seq [LIST_DEPTH];
  int unsigned      held_cnt = 0;

  seq_result_t pending_results [$];

  int unsigned burst_left  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned fail_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned ins_cnt     = 0;
  int unsigned dup_cnt     = 0;
  int unsigned drop_cnt    = 0;

  sink_mode_e  sink_mode   = SINK_OPEN;
  int unsigned mode_left   = 0;

  // Directed rows: wraparound at 0xFFFF/0x0000, the half-range pair 0x7FFF/0x8000,
  // duplicates at both ends, mid-list inserts and numbers exactly half a range
  // away from stored ones. Only the first few answers are obvious by hand.
  seq_row_t dir_rows [DIR_ITEMS] = '{
    '{16'hFFFF, 1'b1, '{STAT_INSERTED,  9'd0, 9'd1}},  // empty list takes it at 0
    '{16'h0000, 1'b1, '{STAT_INSERTED,  9'd1, 9'd2}},  // follows across the wrap
    '{16'hFFFF, 1'b1, '{STAT_DUPLICATE, 9'd0, 9'd2}},  // first probe hits it
    '{16'h0000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h4000, 1'b0, '0},
    '{16'hC000, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h0002, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0},
    '{16'h8001, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h00FF, 1'b0, '0},
    '{16'hFF00, 1'b0, '0}
  };

  sorted_seq_number_insert_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .new_seq_i  (new_seq),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .position_o (position),
    .count_o    (count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // b is newer than a when b - a (mod 2^16) is nonzero and under half range.
  function automatic bit seq_newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && (d < HALF_RANGE);
  endfunction

  // Place one number in the shadow list and return what the block should report.
  function automatic seq_result_t place_seq(logic [SEQ_W-1:0] v);
    seq_result_t r;
    int          lo;
    int          hi;
    int          mid;
    int unsigned slot;
    bit          found;
    r.status = STAT_INSERTED;
    // Full list drops without searching, duplicates included.
    if (held_cnt >= LIST_DEPTH) begin
      r.status   = STAT_FULL;
      r.position = POS_W'(LIST_DEPTH);
      r.count    = POS_W'(held_cnt);
      return r;
    end
    slot = held_cnt;  // empty list or newer than the tail: append
    if (held_cnt != 0 && !seq_newer(held_seq[held_cnt-1], v)) begin
      lo    = 0;
      hi    = int'(held_cnt) - 1;
      found = 1'b0;
      while (!found) begin
        if (lo > hi) begin
          slot  = lo;
          found = 1'b1;
        end else begin
          mid = (lo + hi) / 2;
          if (held_seq[mid] == v) begin
            r.status   = STAT_DUPLICATE;
            r.position = POS_W'(mid);
            r.count    = POS_W'(held_cnt);
            return r;
          end
          if (seq_newer(v, held_seq[mid])) begin
            hi = mid - 1;
          end else if (seq_newer(held_seq[mid], v)) begin
            lo = mid + 1;
          end else begin
            // exactly half a range away: neither side, take this probe's slot
            slot  = mid;
            found = 1'b1;
          end
        end
      end
    end
    for (int unsigned i = held_cnt; i > slot; i--) held_seq[i] = held_seq[i-1];
    held_seq[slot] = v;
    held_cnt++;
    r.position = POS_W'(slot);
    r.count    = POS_W'(held_cnt);
    return r;
  endfunction

  // Source: bursts of random length separated by random gaps. Valid is only
  // dropped at the start of a gap or while draining, so back-to-back items never toggle it.
  task automatic send_seq(input seq_row_t row);
    seq_result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    new_seq  <= row.seq;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    // transfer accepted at this edge
    predicted = place_seq(row.seq);
    pending_results.push_back(row.fixed ? row.result : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    seq_row_t         row;
    logic [SEQ_W-1:0] seq_head;
    int unsigned      pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_seq(dir_rows[i]);
    wait_drained();

    // Mostly packet-like traffic: a head that advances in small steps and wraps
    // past 0xFFFF, late arrivals behind it, and many repeats of stored numbers
    // so the list fills slowly and the full-list drop shows up near the end.
    // The rest is noise and half-range mirrors of stored numbers.
    seq_head = 16'hFFFF - SEQ_W'($urandom_range(0, 255));
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == DRAIN_AT) wait_drained();
      pick       = $urandom_range(0, 99);
      row        = '0;
      if (held_cnt == 0 || (pick >= 76 && pick < 88)) begin
        seq_head = seq_head + SEQ_W'($urandom_range(1, 3));
        row.seq  = seq_head;
      end else if (pick < 76) begin
        row.seq  = held_seq[$urandom_range(0, held_cnt - 1)];
      end else if (pick < 94) begin
        row.seq  = seq_head - SEQ_W'($urandom_range(1, 48));
      end else if (pick < 97) begin
        row.seq  = SEQ_W'($urandom);
      end else begin
        row.seq  = held_seq[$urandom_range(0, held_cnt - 1)] ^ HALF_RANGE;
      end
      send_seq(row);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d results checked: %0d inserted, %0d duplicates, %0d dropped when full",
             result_cnt, ins_cnt, dup_cnt, drop_cnt);
    $display("%0d directed and %0d random numbers sent; list ended with %0d entries",
             DIR_ITEMS, RAND_ITEMS, held_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Sink: stall pattern switches between open, choppy and choked stretches.
  always @(posedge clk_i) begin : sink_stall
    if (mode_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each output transfer with the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    seq_result_t want;
    if (out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d position %0d count %0d",
               status, position, count);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        result_cnt++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_cnt++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, position);
          fail_cnt++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count);
          fail_cnt++;
        end
        case (want.status)
          STAT_INSERTED:  ins_cnt++;
          STAT_DUPLICATE: dup_cnt++;
          default:        drop_cnt++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
